/* rtl/core/sgopa_pkg.sv */
// Shared types and constants of the softmax gradient outer-product accumulator.
package sgopa_pkg;

    // Request codes carried on the request type field.
    localparam logic [2:0] REQ_CLEAR = 3'd0;
    localparam logic [2:0] REQ_PROB  = 3'd1;
    localparam logic [2:0] REQ_FEAT  = 3'd2;
    localparam logic [2:0] REQ_ACCUM = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    // Configuration register indexes and port widths.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_LABELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS   = 2'd1;

    // Arithmetic widths. The class-pair sum width covers up to 16 classes.
    localparam int PROB_W = 16;   // unsigned Q0.16 probability
    localparam int FEAT_W = 16;   // signed Q7.8 feature
    localparam int H_W    = 18;   // signed Q1.16 h term
    localparam int HH_W   = 36;   // product of two h terms, Q.32
    localparam int SSUM_W = 40;   // running class-pair sum, Q.32
    localparam int S_W    = 24;   // class-pair sum truncated to Q.16
    localparam int XX_W   = 32;   // feature product, Q.16
    localparam int PROD_W = 56;   // feature product times pair sum, Q.32
    localparam int INC_W  = 40;   // increment, Q.16
    localparam int ACC_W  = 48;   // accumulator, signed Q31.16
    localparam int SUM_W  = 50;   // accumulator plus increment before saturation

    typedef logic signed [ACC_W-1:0] t_acc;

    // One accumulator word: sticky saturation mark above the value.
    typedef struct packed {
        logic mark;
        t_acc value;
    } t_acc_word;

endpackage

/* rtl/core/softmax_gradient_outer_product_accum.sv */
// Softmax-regression Fisher-information outer-product accumulator, top level.
//
// Command interface: a request is taken when i_start is high and o_busy is low; the one
// result of a read appears with o_result_valid for one cycle, in the cycle after the read
// is taken, and must be captured then. Probability and feature writes and reads do not
// make the block busy. An accumulate request with nonzero class and dimension counts holds
// o_busy through the h-term pass, the class-pair pass and the matrix walk, each followed by a
// drain; the walk updates the accumulator memory through its single write port, one entry per
// cycle. A clear request, and the pass that runs after reset, sweep the whole accumulator
// memory at one entry per cycle; no request is taken during the sweep, while configuration
// writes are always taken.
module softmax_gradient_outer_product_accum #(
    parameter int LABELS = 4,
    parameter int DIMS   = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    output logic                                    o_busy,
    input  logic [2:0]                              i_req_type,
    input  logic [3:0]                              i_elem_index,
    input  logic [sgopa_pkg::PROB_W-1:0]            i_prob_value,
    input  logic signed [sgopa_pkg::FEAT_W-1:0]     i_feature_value,
    input  logic [5:0]                              i_row_index,
    input  logic [5:0]                              i_col_index,
    output logic                                    o_result_valid,
    output logic signed [sgopa_pkg::ACC_W-1:0]      o_entry_value,
    output logic                                    o_saturated_flag,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [sgopa_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sgopa_pkg::CFG_DAT_W-1:0]         i_cfg_data
);

    localparam int MSIDE = LABELS * DIMS;
    localparam int MSIZE = MSIDE * MSIDE;
    localparam int AW    = $clog2(MSIZE);
    localparam int MW    = $clog2(MSIDE);
    localparam int LW    = $clog2(LABELS);
    localparam int DW    = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int NLW   = $clog2(LABELS + 1);
    localparam int NDW   = $clog2(DIMS + 1);
    localparam int HA_W  = $clog2(LABELS * LABELS);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_HTAB  = 3'd2;
    localparam logic [2:0] ST_STAB  = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;

    // Memories.
    logic [sgopa_pkg::PROB_W-1:0]        prob_mem [LABELS];
    logic signed [sgopa_pkg::FEAT_W-1:0] feat_mem [DIMS];
    logic signed [sgopa_pkg::H_W-1:0]    h_mem    [LABELS*LABELS];
    logic signed [sgopa_pkg::S_W-1:0]    pair_mem [LABELS*LABELS];
    sgopa_pkg::t_acc_word                acc_mem  [MSIZE];

    // Control registers.
    logic [2:0]     r_state;
    logic [2:0]     r_after;
    logic [1:0]     r_drain;
    logic [2:0]     r_cfg_labels;
    logic [4:0]     r_cfg_dims;
    logic [LW-1:0]  r_p, r_q, r_k;
    logic [DW-1:0]  r_i, r_j;
    logic [MW-1:0]  r_c;
    logic [AW-1:0]  r_rbase;
    logic [AW-1:0]  r_clr;
    logic           r_h1_v, r_s1_v, r_s2_v, r_w1_v, r_w2_v, r_w3_v, r_rd_pend;

    // Pipeline payload registers.
    logic [sgopa_pkg::PROB_W-1:0]        r_pa, r_pb;
    logic                                r_h1_eq;
    logic [HA_W-1:0]                     r_h1_addr;
    logic signed [sgopa_pkg::H_W-1:0]    r_ha, r_hb;
    logic                                r_s1_first, r_s1_last, r_s2_first, r_s2_last;
    logic [HA_W-1:0]                     r_s1_pq, r_s2_pq;
    logic signed [sgopa_pkg::HH_W-1:0]   r_hh;
    logic signed [sgopa_pkg::SSUM_W-1:0] r_ssum;
    logic signed [sgopa_pkg::FEAT_W-1:0] r_fa, r_fb;
    logic signed [sgopa_pkg::S_W-1:0]    r_pair_rd;
    logic signed [sgopa_pkg::XX_W-1:0]   r_xx;
    logic signed [sgopa_pkg::S_W-1:0]    r_w2_s;
    logic signed [sgopa_pkg::PROD_W-1:0] r_prod;
    logic [AW-1:0]                       r_w1_addr, r_w2_addr, r_w3_addr;
    sgopa_pkg::t_acc_word                r_acc_rd;
    logic                                r_rd_oob;

    // Combinational signals.
    logic                                accept;
    logic [NLW-1:0]                      n_nl, n_lmax;
    logic [NDW-1:0]                      n_nd, n_dmax;
    logic                                p_last, q_last, k_last, i_last, j_last;
    logic                                rd_in_range;
    logic [AW-1:0]                       rd_addr, acc_raddr;
    logic signed [17:0]                  n_h_d;
    logic signed [34:0]                  n_h_prod;
    logic signed [sgopa_pkg::SSUM_W-1:0] n_ssum;
    logic signed [sgopa_pkg::INC_W-1:0]  n_inc;
    logic signed [sgopa_pkg::SUM_W-1:0]  n_sum;
    logic                                n_ovf;
    sgopa_pkg::t_acc_word                n_acc_wr;
    logic                                acc_we;
    logic [AW-1:0]                       acc_waddr;
    sgopa_pkg::t_acc_word                acc_wdata;

    // Row-major index into the class-by-class tables.
    function automatic logic [HA_W-1:0] tab_idx(input logic [LW-1:0] a,
                                                 input logic [LW-1:0] b);
        tab_idx = HA_W'(a) * HA_W'(LABELS) + HA_W'(b);
    endfunction

    assign accept      = i_start && (r_state == ST_IDLE);
    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Effective class and dimension counts, limited to the built sizes.
    always_comb begin
        n_nl   = (int'(r_cfg_labels) > LABELS) ? NLW'(LABELS) : NLW'(r_cfg_labels);
        n_nd   = (int'(r_cfg_dims) > DIMS) ? NDW'(DIMS) : NDW'(r_cfg_dims);
        n_lmax = n_nl - NLW'(1);
        n_dmax = n_nd - NDW'(1);
        p_last = (NLW'(r_p) == n_lmax);
        q_last = (NLW'(r_q) == n_lmax);
        k_last = (NLW'(r_k) == n_lmax);
        i_last = (NDW'(r_i) == n_dmax);
        j_last = (NDW'(r_j) == n_dmax);
    end

    // Read request address and range check.
    assign rd_in_range = (int'(i_row_index) < MSIDE) && (int'(i_col_index) < MSIDE);
    assign rd_addr     = AW'(i_row_index) * AW'(MSIDE) + AW'(i_col_index);
    assign acc_raddr   = (r_state == ST_IDLE) ? rd_addr : r_w2_addr;

    // h term: p's probability times (delta minus k's probability), floored to Q1.16.
    always_comb begin
        n_h_d    = (r_h1_eq ? 18'sd65536 : 18'sd0) - $signed({2'b00, r_pb});
        n_h_prod = $signed({1'b0, r_pa}) * n_h_d;
    end

    // Running class-pair sum over k.
    assign n_ssum = (r_s2_first ? '0 : r_ssum) + sgopa_pkg::SSUM_W'(r_hh);

    // Saturating accumulate of the floored increment.
    always_comb begin
        n_inc = r_prod[sgopa_pkg::PROD_W-1:16];
        n_sum = sgopa_pkg::SUM_W'(r_acc_rd.value) + sgopa_pkg::SUM_W'(n_inc);
        n_ovf = (n_sum[sgopa_pkg::SUM_W-1:sgopa_pkg::ACC_W-1] != 3'b000) &&
                (n_sum[sgopa_pkg::SUM_W-1:sgopa_pkg::ACC_W-1] != 3'b111);
        n_acc_wr.mark = r_acc_rd.mark | n_ovf;
        if (!n_ovf) begin
            n_acc_wr.value = n_sum[sgopa_pkg::ACC_W-1:0];
        end else if (n_sum[sgopa_pkg::SUM_W-1]) begin
            n_acc_wr.value = {1'b1, {(sgopa_pkg::ACC_W-1){1'b0}}};
        end else begin
            n_acc_wr.value = {1'b0, {(sgopa_pkg::ACC_W-1){1'b1}}};
        end
    end

    // The accumulator write port serves the clearing sweep and the last walk stage.
    always_comb begin
        acc_we    = (r_state == ST_CLEAR) || r_w3_v;
        acc_waddr = (r_state == ST_CLEAR) ? r_clr : r_w3_addr;
        acc_wdata = (r_state == ST_CLEAR) ? '0 : n_acc_wr;
    end

    // Accumulator memory: one write and one registered read per cycle. Each entry is
    // visited once per walk, so a read never meets a pending write to the same entry.
    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        r_acc_rd <= acc_mem[acc_raddr];
    end

    // Sample stores, loaded by write requests.
    always_ff @(posedge i_clk) begin
        if (accept && i_req_type == sgopa_pkg::REQ_PROB && int'(i_elem_index) < LABELS) begin
            prob_mem[LW'(i_elem_index)] <= i_prob_value;
        end
        if (accept && i_req_type == sgopa_pkg::REQ_FEAT && int'(i_elem_index) < DIMS) begin
            feat_mem[DW'(i_elem_index)] <= i_feature_value;
        end
        r_pa <= prob_mem[r_p];
        r_pb <= prob_mem[r_k];
        r_fa <= feat_mem[r_i];
        r_fb <= feat_mem[r_j];
    end

    // Class tables: h terms and class-pair sums.
    always_ff @(posedge i_clk) begin
        if (r_h1_v) begin
            h_mem[r_h1_addr] <= n_h_prod[33:16];
        end
        if (r_s2_v && r_s2_last) begin
            pair_mem[r_s2_pq] <= n_ssum[sgopa_pkg::SSUM_W-1:16];
        end
        r_ha      <= h_mem[tab_idx(r_p, r_k)];
        r_hb      <= h_mem[tab_idx(r_q, r_k)];
        r_pair_rd <= pair_mem[tab_idx(r_p, r_q)];
    end

    // Datapath pipeline registers.
    always_ff @(posedge i_clk) begin
        r_h1_eq    <= (r_p == r_k);
        r_h1_addr  <= tab_idx(r_p, r_k);
        r_s1_first <= (r_k == '0);
        r_s1_last  <= k_last;
        r_s1_pq    <= tab_idx(r_p, r_q);
        r_hh       <= r_ha * r_hb;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_pq    <= r_s1_pq;
        if (r_s2_v) begin
            r_ssum <= n_ssum;
        end
        r_w1_addr  <= r_rbase + AW'(r_c);
        r_xx       <= r_fa * r_fb;
        r_w2_s     <= r_pair_rd;
        r_w2_addr  <= r_w1_addr;
        r_prod     <= r_xx * r_w2_s;
        r_w3_addr  <= r_w2_addr;
        r_rd_oob   <= !rd_in_range;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_labels <= 3'd4;
            r_cfg_dims   <= 5'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sgopa_pkg::CFG_LABELS: r_cfg_labels <= i_cfg_data[2:0];
                sgopa_pkg::CFG_DIMS:   r_cfg_dims   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Sequencer: clearing sweep, table passes, matrix walk and pipeline drain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_after   <= ST_IDLE;
            r_drain   <= '0;
            r_clr     <= '0;
            r_p       <= '0;
            r_q       <= '0;
            r_k       <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_c       <= '0;
            r_rbase   <= '0;
            r_h1_v    <= 1'b0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_w1_v    <= 1'b0;
            r_w2_v    <= 1'b0;
            r_w3_v    <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_h1_v    <= 1'b0;
            r_s1_v    <= 1'b0;
            r_w1_v    <= 1'b0;
            r_s2_v    <= r_s1_v;
            r_w2_v    <= r_w1_v;
            r_w3_v    <= r_w2_v;
            r_rd_pend <= accept && (i_req_type == sgopa_pkg::REQ_READ);
            case (r_state)
                ST_IDLE: begin
                    if (accept && i_req_type == sgopa_pkg::REQ_CLEAR) begin
                        r_clr   <= '0;
                        r_state <= ST_CLEAR;
                    end else if (accept && i_req_type == sgopa_pkg::REQ_ACCUM &&
                                 n_nl != '0 && n_nd != '0) begin
                        r_p     <= '0;
                        r_q     <= '0;
                        r_k     <= '0;
                        r_state <= ST_HTAB;
                    end
                end
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MSIZE - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_HTAB: begin
                    r_h1_v <= 1'b1;
                    r_k    <= k_last ? '0 : r_k + LW'(1);
                    if (k_last) begin
                        r_p <= p_last ? '0 : r_p + LW'(1);
                        if (p_last) begin
                            r_after <= ST_STAB;
                            r_drain <= 2'd3;
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_STAB: begin
                    r_s1_v <= 1'b1;
                    r_k    <= k_last ? '0 : r_k + LW'(1);
                    if (k_last) begin
                        r_q <= q_last ? '0 : r_q + LW'(1);
                        if (q_last) begin
                            r_p <= p_last ? '0 : r_p + LW'(1);
                            if (p_last) begin
                                r_i     <= '0;
                                r_j     <= '0;
                                r_c     <= '0;
                                r_rbase <= '0;
                                r_after <= ST_WALK;
                                r_drain <= 2'd3;
                                r_state <= ST_DRAIN;
                            end
                        end
                    end
                end
                ST_WALK: begin
                    // Column runs q*D+j, row base steps one row per (q,j) wrap.
                    r_w1_v <= 1'b1;
                    r_j    <= j_last ? '0 : r_j + DW'(1);
                    r_c    <= r_c + MW'(1);
                    if (j_last) begin
                        r_q <= q_last ? '0 : r_q + LW'(1);
                        if (q_last) begin
                            r_c     <= '0;
                            r_rbase <= r_rbase + AW'(MSIDE);
                            r_i     <= i_last ? '0 : r_i + DW'(1);
                            if (i_last) begin
                                r_p <= p_last ? '0 : r_p + LW'(1);
                                if (p_last) begin
                                    r_after <= ST_IDLE;
                                    r_drain <= 2'd3;
                                    r_state <= ST_DRAIN;
                                end
                            end
                        end
                    end
                end
                ST_DRAIN: begin
                    r_drain <= r_drain - 2'd1;
                    if (r_drain == 2'd0) begin
                        r_state <= r_after;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Read result, registered from the read transfer and shown for one cycle.
    assign o_result_valid   = r_rd_pend;
    assign o_entry_value    = r_rd_oob ? '0 : r_acc_rd.value;
    assign o_saturated_flag = r_rd_oob ? 1'b0 : r_acc_rd.mark;

    // A result strobe follows a read transfer and nothing else.
    a_result_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(accept && i_req_type == sgopa_pkg::REQ_READ))
        else $error("result strobe without a preceding read transfer");

    // No request is taken while any pipeline stage still holds work.
    a_accept_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !(r_h1_v || r_s1_v || r_s2_v || r_w1_v || r_w2_v || r_w3_v))
        else $error("request taken while the pipeline is not drained");

    // Walk write-backs only land during the walk or its drain, never in the clearing sweep.
    a_walk_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w3_v |-> (r_state == ST_WALK || r_state == ST_DRAIN))
        else $error("accumulator write-back outside the walk");

endmodule

/* sim/tb_softmax_gradient_outer_product_accum.sv */
// Testbench for the Fisher-information outer-product accumulator: predicted matrix versus reads.
`timescale 1ns / 100ps

module tb_softmax_gradient_outer_product_accum;
    import sgopa_pkg::*;

    localparam int N_LABELS    = 4;
    localparam int N_DIMS      = 16;
    localparam int MSIDE       = N_LABELS * N_DIMS;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 18;
    localparam int IDLE_PAUSE  = 4400;
    localparam int END_CYCLES  = 50;
    localparam int RUN_LIMIT   = 3_000_000;
    localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    // Request codes the block ignores.
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    // One request as it is presented on the command ports.
    typedef struct {
        logic [2:0]         kind;
        logic [3:0]         idx;
        logic [15:0]        prob;
        logic signed [15:0] feat;
        logic [5:0]         row;
        logic [5:0]         col;
    } request_t;

    // Mirror of the sample stores and the accumulator matrix, with the reads still owed.
    class fisher_matrix_shadow;
        logic [2:0]         labels_reg;
        logic [4:0]         dims_reg;
        logic [15:0]        prob_mem [N_LABELS];
        logic signed [15:0] feat_mem [N_DIMS];
        longint             acc_mem  [MSIDE*MSIDE];
        bit                 mark_mem [MSIDE*MSIDE];
        t_acc_word          read_queue [$];
        int                 mismatches;
        int                 reads_checked;

        function new();
            labels_reg = 3'd4;
            dims_reg   = 5'd16;
            foreach (prob_mem[k]) prob_mem[k] = '0;
            foreach (feat_mem[k]) feat_mem[k] = '0;
            wipe_matrix();
        endfunction

        function void wipe_matrix();
            foreach (acc_mem[a]) begin
                acc_mem[a]  = 0;
                mark_mem[a] = 1'b0;
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
            if (index == CFG_LABELS) begin
                labels_reg = data[2:0];
            end else if (index == CFG_DIMS) begin
                dims_reg = data[4:0];
            end
        endfunction

        // Register values above the built sizes act as the built sizes.
        function int classes_used();
            return (labels_reg > N_LABELS) ? N_LABELS : int'(labels_reg);
        endfunction

        function int dims_used();
            return (dims_reg > N_DIMS) ? N_DIMS : int'(dims_reg);
        endfunction

        // pi_p * (delta_pk - pi_k) floored to Q1.16.
        function longint h_term(int p, int k);
            longint diff;
            diff = ((p == k) ? 64'sd65536 : 64'sd0) - longint'(prob_mem[k]);
            return (longint'(prob_mem[p]) * diff) >>> 16;
        endfunction

        // One accumulate pass: class-pair sums first, then every entry in use.
        function void fold_in_sample();
            longint pair_sum [N_LABELS][N_LABELS];
            longint s, xx, inc, v;
            int nl, nd, a;
            nl = classes_used();
            nd = dims_used();
            for (int p = 0; p < nl; p++) begin
                for (int q = 0; q < nl; q++) begin
                    s = 0;
                    for (int k = 0; k < nl; k++) s += h_term(p, k) * h_term(q, k);
                    pair_sum[p][q] = s >>> 16;
                end
            end
            for (int p = 0; p < nl; p++) begin
                for (int i = 0; i < nd; i++) begin
                    for (int q = 0; q < nl; q++) begin
                        for (int j = 0; j < nd; j++) begin
                            a   = (p * nd + i) * MSIDE + (q * nd + j);
                            xx  = longint'(feat_mem[i]) * longint'(feat_mem[j]);
                            inc = (xx * pair_sum[p][q]) >>> 16;
                            v   = acc_mem[a] + inc;
                            if (v > ACC_MAX) begin
                                v = ACC_MAX;
                                mark_mem[a] = 1'b1;
                            end
                            if (v < ACC_MIN) begin
                                v = ACC_MIN;
                                mark_mem[a] = 1'b1;
                            end
                            acc_mem[a] = v;
                        end
                    end
                end
            end
        endfunction

        // Called for every request the block has taken.
        function void apply_request(request_t rq);
            t_acc_word want;
            case (rq.kind)
                REQ_CLEAR: wipe_matrix();
                REQ_PROB: begin
                    if (rq.idx < N_LABELS) prob_mem[rq.idx] = rq.prob;
                end
                REQ_FEAT: begin
                    if (rq.idx < N_DIMS) feat_mem[rq.idx] = rq.feat;
                end
                REQ_ACCUM: fold_in_sample();
                REQ_READ: begin
                    if (rq.row < MSIDE && rq.col < MSIDE) begin
                        want.value = t_acc'(acc_mem[rq.row * MSIDE + rq.col]);
                        want.mark  = mark_mem[rq.row * MSIDE + rq.col];
                    end else begin
                        want.value = '0;
                        want.mark  = 1'b0;
                    end
                    read_queue.push_back(want);
                end
                default: ;
            endcase
        endfunction

        // Called for every result strobe.
        function void compare_read(t_acc value, logic mark);
            t_acc_word want;
            if (read_queue.size() == 0) begin
                $error("entry result with no read outstanding: entry_value %0d", value);
                mismatches++;
                return;
            end
            want = read_queue.pop_front();
            reads_checked++;
            if (value !== want.value) begin
                $error("entry_value mismatch: expected %0d, actual %0d", want.value, value);
                mismatches++;
            end
            if (mark !== want.mark) begin
                $error("saturated_flag mismatch: expected %0b, actual %0b", want.mark, mark);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic [2:0]            i_req_type;
    logic [3:0]            i_elem_index;
    logic [PROB_W-1:0]     i_prob_value;
    logic signed [FEAT_W-1:0] i_feature_value;
    logic [5:0]            i_row_index;
    logic [5:0]            i_col_index;
    logic                  o_result_valid;
    logic signed [ACC_W-1:0] o_entry_value;
    logic                  o_saturated_flag;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DAT_W-1:0]  i_cfg_data;

    fisher_matrix_shadow shadow = new();
    int  cycle_count = 0;
    int  phase_items;
    int  n_requests = 0;
    int  n_accums = 0;
    int  n_clears = 0;
    bit  steady;
    int  phase_labels [PHASES] = '{4, 2, 7, 0, 1, 3, 5, 4};
    int  phase_dims   [PHASES] = '{16, 1, 31, 9, 5, 0, 12, 16};

    softmax_gradient_outer_product_accum #(
        .LABELS (N_LABELS),
        .DIMS   (N_DIMS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_req_type       (i_req_type),
        .i_elem_index     (i_elem_index),
        .i_prob_value     (i_prob_value),
        .i_feature_value  (i_feature_value),
        .i_row_index      (i_row_index),
        .i_col_index      (i_col_index),
        .o_result_valid   (o_result_valid),
        .o_entry_value    (o_entry_value),
        .o_saturated_flag (o_saturated_flag),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Every result strobe is checked at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) shadow.compare_read(o_entry_value, o_saturated_flag);
    end

    // Read indexes fall mostly inside the part of the matrix in use.
    function automatic logic [5:0] pick_cell();
        int used;
        used = shadow.classes_used() * shadow.dims_used();
        if (used > 0 && $urandom_range(0, 4) != 0) return 6'($urandom_range(0, used - 1));
        return 6'($urandom_range(0, MSIDE - 1));
    endfunction

    // Random content for every field, with the fields that matter shaped for the request.
    function automatic request_t random_request(logic [2:0] kind);
        request_t rq;
        rq.kind = kind;
        rq.idx  = 4'($urandom);
        rq.row  = 6'($urandom);
        rq.col  = 6'($urandom);
        case ($urandom_range(0, 5))
            0:       rq.prob = 16'h0000;
            1:       rq.prob = 16'hFFFF;
            default: rq.prob = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       rq.feat = 16'sh8000;
            1:       rq.feat = 16'sh7FFF;
            2, 3:    rq.feat = 16'($signed($urandom_range(0, 1023)) - 512);
            default: rq.feat = 16'($urandom);
        endcase
        if (kind == REQ_PROB) begin
            rq.idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(N_LABELS, 15))
                                                  : 4'($urandom_range(0, N_LABELS - 1));
        end else if (kind == REQ_READ) begin
            rq.row = pick_cell();
            rq.col = pick_cell();
        end
        return rq;
    endfunction

    // Present one request after a random gap and wait for its transfer.
    task automatic send_request(input request_t rq);
        int gap;
        gap = 0;
        if (!steady) begin
            case ($urandom_range(0, 19))
                14, 15, 16, 17, 18: gap = $urandom_range(1, 3);
                19:                 gap = $urandom_range(10, 40);
                default:            gap = 0;
            endcase
        end
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_req_type      <= rq.kind;
        i_elem_index    <= rq.idx;
        i_prob_value    <= rq.prob;
        i_feature_value <= rq.feat;
        i_row_index     <= rq.row;
        i_col_index     <= rq.col;
        do @(posedge i_clk); while (o_busy);
        shadow.apply_request(rq);
        n_requests++;
        if (rq.kind == REQ_ACCUM) n_accums++;
        if (rq.kind == REQ_CLEAR) n_clears++;
        // Ignored requests do not count toward the phase length.
        if (rq.kind <= REQ_READ && !(rq.kind == REQ_PROB && rq.idx >= N_LABELS)) phase_items++;
    endtask

    // Hold off new requests until every read result has come back.
    task automatic wait_drained();
        i_start <= 1'b0;
        do @(posedge i_clk); while (shadow.read_queue.size() != 0);
    endtask

    // Both size registers, back to back on the write channel.
    task automatic program_sizes(input int labels, input int dims);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_LABELS;
        i_cfg_data  <= CFG_DAT_W'(labels);
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow.set_register(CFG_LABELS, CFG_DAT_W'(labels));
        i_cfg_index <= CFG_DIMS;
        i_cfg_data  <= CFG_DAT_W'(dims);
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow.set_register(CFG_DIMS, CFG_DAT_W'(dims));
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly a load-accumulate-read sequence; sometimes a single request of any kind.
    task automatic run_sequence();
        int n;
        steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) < 7) begin
            n = $urandom_range(0, N_LABELS);
            repeat (n) send_request(random_request(REQ_PROB));
            n = $urandom_range(0, 3);
            repeat (n) send_request(random_request(REQ_FEAT));
            if ($urandom_range(0, 19) == 0) send_request(random_request(REQ_CLEAR));
            if ($urandom_range(0, 9) < 8) send_request(random_request(REQ_ACCUM));
            n = $urandom_range(1, 4);
            repeat (n) send_request(random_request(REQ_READ));
        end else begin
            send_request(random_request(3'($urandom_range(0, REQ_SPARE_HI))));
        end
    endtask

    initial begin
        request_t rq;
        int seq_no;
        i_rst_n         <= 1'b0;
        i_start         <= 1'b0;
        i_req_type      <= REQ_CLEAR;
        i_elem_index    <= '0;
        i_prob_value    <= '0;
        i_feature_value <= '0;
        i_row_index     <= '0;
        i_col_index     <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_LABELS;
        i_cfg_data      <= '0;
        steady = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        program_sizes(phase_labels[0], phase_dims[0]);

        // Directed start: load every class and dimension before the first accumulate.
        for (int k = 0; k < N_LABELS; k++) begin
            rq = random_request(REQ_PROB);
            rq.idx = 4'(k);
            case (k)
                0:       rq.prob = 16'hFFFF;
                1:       rq.prob = 16'h0000;
                2:       rq.prob = 16'h8000;
                default: rq.prob = 16'h5555;
            endcase
            send_request(rq);
        end
        // A probability write past the last class must leave the store alone.
        rq = random_request(REQ_PROB);
        rq.idx = 4'd12;
        send_request(rq);
        for (int k = 0; k < N_DIMS; k++) begin
            rq = random_request(REQ_FEAT);
            rq.idx = 4'(k);
            case (k)
                0:       rq.feat = 16'sh8000;
                1:       rq.feat = 16'sh7FFF;
                2:       rq.feat = 16'sh0000;
                3:       rq.feat = -16'sd1;
                4:       rq.feat = 16'sd1;
                5:       rq.feat = 16'sh0100;
                6:       rq.feat = 16'shFF00;
                default: ;
            endcase
            send_request(rq);
        end
        send_request(random_request(REQ_ACCUM));
        rq = random_request(REQ_READ);
        rq.row = 6'd0;
        rq.col = 6'd0;
        send_request(rq);
        send_request(random_request(REQ_SPARE_HI));
        // Clear, then read back the corner that was just the largest.
        send_request(random_request(REQ_CLEAR));
        send_request(rq);

        // Random phases, each under its own size setting.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                repeat (IDLE_PAUSE) @(posedge i_clk);
                while (o_busy) @(posedge i_clk);
                program_sizes(phase_labels[ph], phase_dims[ph]);
            end
            phase_items = 0;
            seq_no = 0;
            while (phase_items < PHASE_ITEMS) begin
                run_sequence();
                seq_no++;
                if (seq_no == 2 || $urandom_range(0, 9) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (shadow.read_queue.size() != 0) begin
            $error("%0d entry reads never returned a result", shadow.read_queue.size());
            shadow.mismatches++;
        end
        $display("Sent %0d requests (%0d accumulates, %0d clears) across %0d size settings.",
                 n_requests, n_accums, n_clears, PHASES);
        $display("Compared %0d entry reads against the predicted matrix.",
                 shadow.reads_checked);
        if (shadow.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
